// ===== rtl/call_target_line_parser_core_assert.svh =====
// Assertion macros shared by the parser RTL.
`ifndef CALL_TARGET_LINE_PARSER_CORE_ASSERT_SVH
`define CALL_TARGET_LINE_PARSER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTLP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ctlp_pkg.sv =====
package ctlp_pkg;

   // Longest accepted hex operand and the counter width that holds it.
   localparam int MaxHexDigits   = 16;
   localparam int DigitCountWidth = $clog2(MaxHexDigits + 1);

   localparam int CharWidth   = 8;
   localparam int TargetWidth = 64;
   localparam int DigitWidth  = 4;

   // Character codes used by the parser.
   localparam logic [CharWidth-1:0] CharSpace = 8'h20;
   localparam logic [CharWidth-1:0] CharTab   = 8'h09;
   localparam logic [CharWidth-1:0] CharZero  = 8'h30;
   localparam logic [CharWidth-1:0] CharLowX  = 8'h78;

   // The mnemonic, in lower case.
   localparam logic [CharWidth-1:0] CallWord [4] = '{8'h63, 8'h61, 8'h6c, 8'h6c};

   // One result word.
   typedef struct packed {
      logic                   found;
      logic [TargetWidth-1:0] target;
   } result_type;

   function automatic logic is_blank(input logic [CharWidth-1:0] c);
      return (c == CharSpace) || (c == CharTab);
   endfunction

   function automatic logic [CharWidth-1:0] to_lower(input logic [CharWidth-1:0] c);
      if (c >= 8'h41 && c <= 8'h5a) begin
         return c + 8'd32;
      end
      return c;
   endfunction

   // Bit 4 set means the character is not a hex digit.
   function automatic logic [DigitWidth:0] hex_value(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] d;
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
         return d[DigitWidth:0];
      end
      if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
         return d[DigitWidth:0];
      end
      if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
         return d[DigitWidth:0];
      end
      return 5'h10;
   endfunction

endpackage

// ===== rtl/ctlp_parse.sv =====
`include "call_target_line_parser_core_assert.svh"

module ctlp_parse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [ctlp_pkg::CharWidth-1:0] ch,
   input  logic                          has_char,
   input  logic                          end_of_row,
   output ctlp_pkg::result_type          result
);
   import ctlp_pkg::*;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_MNEM,
      PH_GAP,
      PH_X,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   phase_type                  phase_ff, phase_in, phase_upd;
   logic [2:0]                 mnem_count_ff, mnem_count_in, mnem_count_upd;
   logic                       mnem_ok_ff, mnem_ok_in, mnem_ok_upd;
   logic [TargetWidth-1:0]     acc_ff, acc_in, acc_upd;
   logic [DigitCountWidth-1:0] digit_count_ff, digit_count_in, digit_count_upd;
   logic                       rejected_ff, rejected_in, rejected_upd;

   logic                       blank;
   logic [DigitWidth:0]        hexv;
   logic                       letter_match;
   logic                       found;

   assign blank = is_blank(ch);
   assign hexv  = hex_value(ch);
   assign letter_match = (mnem_count_ff < 3'd4) &&
                         (to_lower(ch) == CallWord[mnem_count_ff[1:0]]);

   // Apply one character to the row state.
   always_comb begin
      phase_upd       = phase_ff;
      mnem_count_upd  = mnem_count_ff;
      mnem_ok_upd     = mnem_ok_ff;
      acc_upd         = acc_ff;
      digit_count_upd = digit_count_ff;
      rejected_upd    = rejected_ff;
      if (has_char && !rejected_ff) begin
         unique case (phase_ff)
            PH_LEAD, PH_MNEM: begin
               if (phase_ff == PH_MNEM && blank) begin
                  if (mnem_count_ff == 3'd4 && mnem_ok_ff) begin
                     phase_upd = PH_GAP;
                  end else begin
                     rejected_upd = 1'b1;
                  end
               end else if (!blank) begin
                  phase_upd = PH_MNEM;
                  if (!letter_match) begin
                     mnem_ok_upd = 1'b0;
                  end
                  if (mnem_count_ff < 3'd4) begin
                     mnem_count_upd = mnem_count_ff + 3'd1;
                  end
               end
            end
            PH_GAP: begin
               if (!blank) begin
                  if (ch == CharZero) begin
                     phase_upd = PH_X;
                  end else begin
                     rejected_upd = 1'b1;
                  end
               end
            end
            PH_X: begin
               if (ch == CharLowX) begin
                  phase_upd = PH_DIGITS;
               end else begin
                  rejected_upd = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (hexv[DigitWidth]) begin
                  phase_upd = PH_DONE;
               end else if (digit_count_ff >= DigitCountWidth'(MaxHexDigits)) begin
                  rejected_upd = 1'b1;
               end else begin
                  acc_upd         = {acc_ff[TargetWidth-DigitWidth-1:0],
                                     hexv[DigitWidth-1:0]};
                  digit_count_upd = digit_count_ff + DigitCountWidth'(1);
               end
            end
            default: begin
               // After the number the rest of the row is ignored.
            end
         endcase
      end
   end

   // Verdict on the row as it stands after this character.
   assign found = !rejected_upd && (phase_upd == PH_DIGITS || phase_upd == PH_DONE) &&
                  (digit_count_upd != '0);
   assign result.found  = found;
   assign result.target = found ? acc_upd : '0;

   // The last item of a row clears the state for the next row.
   always_comb begin
      if (end_of_row) begin
         phase_in       = PH_LEAD;
         mnem_count_in  = 3'd0;
         mnem_ok_in     = 1'b1;
         acc_in         = '0;
         digit_count_in = '0;
         rejected_in    = 1'b0;
      end else begin
         phase_in       = phase_upd;
         mnem_count_in  = mnem_count_upd;
         mnem_ok_in     = mnem_ok_upd;
         acc_in         = acc_upd;
         digit_count_in = digit_count_upd;
         rejected_in    = rejected_upd;
      end
   end

   // Row state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEAD;
         mnem_count_ff  <= 3'd0;
         mnem_ok_ff     <= 1'b1;
         acc_ff         <= '0;
         digit_count_ff <= '0;
         rejected_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         mnem_count_ff  <= mnem_count_in;
         mnem_ok_ff     <= mnem_ok_in;
         acc_ff         <= acc_in;
         digit_count_ff <= digit_count_in;
         rejected_ff    <= rejected_in;
      end
   end

   `CTLP_ASSERT_NEXT(a_row_cleared, step_en && end_of_row,
      phase_ff == PH_LEAD && digit_count_ff == '0 && !rejected_ff && acc_ff == '0,
      "row state not cleared after end of row")
   `CTLP_ASSERT_SAME(a_digit_bound, 1'b1,
      digit_count_ff <= DigitCountWidth'(MaxHexDigits),
      "digit count beyond the operand limit")
   `CTLP_ASSERT_SAME(a_lead_no_mnem, phase_ff == PH_LEAD,
      mnem_count_ff == 3'd0 && digit_count_ff == '0,
      "mnemonic or digits counted during leading blanks")

endmodule

// ===== rtl/ctlp_rsp_reg.sv =====
module ctlp_rsp_reg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  ctlp_pkg::result_type            result,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [ctlp_pkg::TargetWidth-1:0] rsp_target
);
   import ctlp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // A word stays until taken; a new one may load as the old one leaves.
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_found  = data_ff.found;
   assign rsp_target = data_ff.target;

endmodule

// ===== rtl/call_target_line_parser_core.sv =====
// Path: each word is taken into the input register; the parse logic then steps the row
// state, and a row's last word loads its result word into the result register.
// Throughput: one word per cycle; a row's last word waits only while a previous
// result word is stalled in the result register.
// Reset (synchronous, active high) empties both registers and returns the row
// parser to the leading-blank state.
`include "call_target_line_parser_core_assert.svh"

module call_target_line_parser_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ctlp_pkg::CharWidth-1:0]  req_ch,
   input  logic                            req_has_char,
   input  logic                            req_end_of_row,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [ctlp_pkg::TargetWidth-1:0] rsp_target
);
   import ctlp_pkg::*;

   logic                 in_valid_ff;
   logic [CharWidth-1:0] in_ch_ff;
   logic                 in_has_ff;
   logic                 in_eor_ff;
   logic                 advance;
   result_type           result;

   // The held word moves on unless it ends a row and the result register holds a stalled word.
   assign advance   = in_valid_ff && (!in_eor_ff || !rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ch_ff  <= req_ch;
         in_has_ff <= req_has_char;
         in_eor_ff <= req_end_of_row;
      end
   end

   ctlp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .ch         (in_ch_ff),
      .has_char   (in_has_ff),
      .end_of_row (in_eor_ff),
      .result     (result)
   );

   ctlp_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && in_eor_ff),
      .result     (result),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_found  (rsp_found),
      .rsp_target (rsp_target)
   );

   `CTLP_ASSERT_SAME(a_stall_needs_word, req_stall,
      in_valid_ff && in_eor_ff && rsp_valid && rsp_stall,
      "input stalled without a blocked row end")

endmodule
